// ----- hdl/dpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// dpsc_pkg: shared types for the directional PID speed controller
// Item formats of the request and response channels and the register indexes.
// ----------------------------------------------------------------------------
package dpsc_pkg;

   // Configuration port geometry
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 16;

   // Register indexes; index 7 is unused and ignored on write
   typedef enum logic [CsrAddrW-1:0] {
      CSR_TARGET_SPEED = 3'd0,
      CSR_DIR_X        = 3'd1,
      CSR_DIR_Y        = 3'd2,
      CSR_DIR_Z        = 3'd3,
      CSR_GAIN_P       = 3'd4,
      CSR_GAIN_I       = 3'd5,
      CSR_GAIN_D       = 3'd6
   } csr_index_type;

   // Request item: drive flag, velocity (Q8.8), tick length (Q0.16)
   typedef struct packed {
      logic               drive_on;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] vel_z;
      logic        [15:0] step_time;
   } req_type;

   // Response item: force along the direction (Q16.16, saturated)
   typedef struct packed {
      logic               drive_active;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
   } rsp_type;

endpackage

// ----- hdl/directional_pid_speed_control.sv -----
// ----------------------------------------------------------------------------
// directional_pid_speed_control: PID speed loop along a configured direction
// One shared 33x18 multiplier under a sequencer computes the projection,
// the integral update, the PID sum and the output force per tick.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per control tick (drive flag, velocity, tick length).
//            Accepted when req_valid and req_ready are both high.
//   rsp_*  : exactly one result item per request item, in order.
//   csr_*  : register writes, taken on any edge with csr_we high; write only
//            while no item is in flight. Index 7 is ignored.
// Timing:
//   A drive-on item runs 16 sequencer steps on the shared multiplier (eleven
//   products, one issued per step, each registered before use), then one
//   step to hand the result to the output register once it is free. A
//   drive-off item clears the integral and last error and goes straight to
//   the hand-off step. A new item is taken only once the sequencer is idle,
//   so none is accepted until the previous one has been handed off.
// Reset:
//   Synchronous. Registers return to target 0, direction (1,0,0), gains 0;
//   the integral and last error are cleared and no result is pending.
// Stall:
//   The output register holds its item until rsp_ready. A finished item
//   waits in the sequencer until the output register is free; the next
//   request may be accepted while a result still waits on rsp.
// ----------------------------------------------------------------------------
module directional_pid_speed_control (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  dpsc_pkg::req_type                   req_data,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output dpsc_pkg::rsp_type                   rsp_data,
   // configuration port
   input  logic                                csr_we,
   input  logic [dpsc_pkg::CsrAddrW-1:0]       csr_addr,
   input  logic [dpsc_pkg::CsrDataW-1:0]       csr_wdata
);
   import dpsc_pkg::*;

   localparam logic signed [31:0] W32Max = 32'sh7fffffff;
   localparam logic signed [31:0] W32Min = 32'sh80000000;
   localparam logic signed [47:0] SumMax = 48'sh7fffffffffff;
   localparam logic signed [47:0] SumMin = 48'sh800000000000;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_VX,
      ST_MUL_VY,
      ST_MUL_VZ,
      ST_DOT_END,
      ST_ERROR,
      ST_MUL_DT,
      ST_MUL_P,
      ST_MUL_D,
      ST_MUL_ILO,
      ST_MUL_IHI,
      ST_ACC_END,
      ST_SAT_U,
      ST_MUL_FX,
      ST_MUL_FY,
      ST_MUL_FZ,
      ST_FZ,
      ST_DONE
   } state_type;

   // Saturate dir*u >>> 14 to 32 bits
   function automatic logic signed [31:0] sat_force(input logic signed [50:0] p);
      logic signed [31:0] r;
      if ((&p[50:45]) || !(|p[50:45])) begin
         r = p[45:14];
      end else begin
         r = p[50] ? W32Min : W32Max;
      end
      return r;
   endfunction

   // Control and state registers
   state_type          state_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic signed [15:0] target_speed_ff;
   logic signed [15:0] dir_x_ff;
   logic signed [15:0] dir_y_ff;
   logic signed [15:0] dir_z_ff;
   logic signed [15:0] gain_p_ff;
   logic signed [15:0] gain_i_ff;
   logic signed [15:0] gain_d_ff;
   logic signed [31:0] last_error_ff;
   logic signed [47:0] error_sum_ff;

   // Datapath registers
   req_type            req_ff;
   logic signed [50:0] prod_ff;
   logic signed [65:0] acc_ff;
   logic signed [31:0] e_ff;
   logic signed [32:0] d_ff;
   logic signed [31:0] u_ff;
   logic               active_ff;
   logic signed [31:0] force_x_ff;
   logic signed [31:0] force_y_ff;
   logic signed [31:0] force_z_ff;

   // Combinational values
   logic signed [32:0] mul_a_in;
   logic signed [17:0] mul_b_in;
   logic signed [65:0] prod_ext;
   logic signed [31:0] e_in;
   logic signed [32:0] d_in;
   logic signed [48:0] sum_wide;
   logic signed [47:0] error_sum_in;
   logic signed [31:0] u_in;
   logic               req_fire;
   logic               rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Operand select for the shared multiplier
   always_comb begin
      mul_a_in = '0;
      mul_b_in = '0;
      unique case (state_ff)
         ST_MUL_VX: begin
            mul_a_in = {{17{req_ff.vel_x[15]}}, req_ff.vel_x};
            mul_b_in = {{2{dir_x_ff[15]}}, dir_x_ff};
         end
         ST_MUL_VY: begin
            mul_a_in = {{17{req_ff.vel_y[15]}}, req_ff.vel_y};
            mul_b_in = {{2{dir_y_ff[15]}}, dir_y_ff};
         end
         ST_MUL_VZ: begin
            mul_a_in = {{17{req_ff.vel_z[15]}}, req_ff.vel_z};
            mul_b_in = {{2{dir_z_ff[15]}}, dir_z_ff};
         end
         ST_MUL_DT: begin
            mul_a_in = {e_ff[31], e_ff};
            mul_b_in = {2'b00, req_ff.step_time};
         end
         ST_MUL_P: begin
            mul_a_in = {e_ff[31], e_ff};
            mul_b_in = {{2{gain_p_ff[15]}}, gain_p_ff};
         end
         ST_MUL_D: begin
            mul_a_in = d_ff;
            mul_b_in = {{2{gain_d_ff[15]}}, gain_d_ff};
         end
         ST_MUL_ILO: begin
            // low 16 bits of the integral as an unsigned part
            mul_a_in = {17'b0, error_sum_ff[15:0]};
            mul_b_in = {{2{gain_i_ff[15]}}, gain_i_ff};
         end
         ST_MUL_IHI: begin
            mul_a_in = {error_sum_ff[47], error_sum_ff[47:16]};
            mul_b_in = {{2{gain_i_ff[15]}}, gain_i_ff};
         end
         ST_MUL_FX: begin
            mul_a_in = {u_ff[31], u_ff};
            mul_b_in = {{2{dir_x_ff[15]}}, dir_x_ff};
         end
         ST_MUL_FY: begin
            mul_a_in = {u_ff[31], u_ff};
            mul_b_in = {{2{dir_y_ff[15]}}, dir_y_ff};
         end
         ST_MUL_FZ: begin
            mul_a_in = {u_ff[31], u_ff};
            mul_b_in = {{2{dir_z_ff[15]}}, dir_z_ff};
         end
         default: begin
            mul_a_in = '0;
            mul_b_in = '0;
         end
      endcase
   end

   // Error, derivative, integral and control-value arithmetic
   always_comb begin
      prod_ext = {{15{prod_ff[50]}}, prod_ff};
      // e = target<<8 - (dot >>> 6); dot fits 34 bits, e fits 32
      e_in = {{8{target_speed_ff[15]}}, target_speed_ff, 8'b0} - acc_ff[37:6];
      d_in = {e_ff[31], e_ff} - {last_error_ff[31], last_error_ff};
      // integral step: (e*dt) >>> 16, then saturate to 48 bits
      sum_wide = {error_sum_ff[47], error_sum_ff}
               + {{14{prod_ff[50]}}, prod_ff[50:16]};
      if (sum_wide[48] != sum_wide[47]) begin
         error_sum_in = sum_wide[48] ? SumMin : SumMax;
      end else begin
         error_sum_in = sum_wide[47:0];
      end
      // u = sat32(acc >>> 8)
      if ((&acc_ff[65:39]) || !(|acc_ff[65:39])) begin
         u_in = acc_ff[39:8];
      end else begin
         u_in = acc_ff[65] ? W32Min : W32Max;
      end
   end

   // Shared multiplier, product registered
   always_ff @(posedge clock) begin
      prod_ff <= mul_a_in * mul_b_in;
   end

   // Sequencer, registers and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         target_speed_ff <= '0;
         dir_x_ff        <= 16'sd16384;
         dir_y_ff        <= '0;
         dir_z_ff        <= '0;
         gain_p_ff       <= '0;
         gain_i_ff       <= '0;
         gain_d_ff       <= '0;
         last_error_ff   <= '0;
         error_sum_ff    <= '0;
      end else begin
         // register writes
         if (csr_we) begin
            unique case (csr_addr)
               CSR_TARGET_SPEED: target_speed_ff <= csr_wdata;
               CSR_DIR_X:        dir_x_ff        <= csr_wdata;
               CSR_DIR_Y:        dir_y_ff        <= csr_wdata;
               CSR_DIR_Z:        dir_z_ff        <= csr_wdata;
               CSR_GAIN_P:       gain_p_ff       <= csr_wdata;
               CSR_GAIN_I:       gain_i_ff       <= csr_wdata;
               CSR_GAIN_D:       gain_d_ff       <= csr_wdata;
               default: ;
            endcase
         end

         // output register drains; a hand-off in ST_DONE refills it instead
         if (rsp_valid_ff && rsp_ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  req_ff <= req_data;
                  if (req_data.drive_on) begin
                     active_ff <= 1'b1;
                     state_ff  <= ST_MUL_VX;
                  end else begin
                     // drive off: controller reset, zero force
                     active_ff     <= 1'b0;
                     force_x_ff    <= '0;
                     force_y_ff    <= '0;
                     force_z_ff    <= '0;
                     last_error_ff <= '0;
                     error_sum_ff  <= '0;
                     state_ff      <= ST_DONE;
                  end
               end
            end
            ST_MUL_VX: state_ff <= ST_MUL_VY;
            ST_MUL_VY: begin
               acc_ff   <= prod_ext;
               state_ff <= ST_MUL_VZ;
            end
            ST_MUL_VZ: begin
               acc_ff   <= acc_ff + prod_ext;
               state_ff <= ST_DOT_END;
            end
            ST_DOT_END: begin
               acc_ff   <= acc_ff + prod_ext;
               state_ff <= ST_ERROR;
            end
            ST_ERROR: begin
               e_ff     <= e_in;
               state_ff <= ST_MUL_DT;
            end
            ST_MUL_DT: begin
               d_ff     <= d_in;
               state_ff <= ST_MUL_P;
            end
            ST_MUL_P: begin
               error_sum_ff  <= error_sum_in;
               last_error_ff <= e_ff;
               state_ff      <= ST_MUL_D;
            end
            ST_MUL_D: begin
               acc_ff   <= prod_ext;
               state_ff <= ST_MUL_ILO;
            end
            ST_MUL_ILO: begin
               acc_ff   <= acc_ff + prod_ext;
               state_ff <= ST_MUL_IHI;
            end
            ST_MUL_IHI: begin
               acc_ff   <= acc_ff + prod_ext;
               state_ff <= ST_ACC_END;
            end
            ST_ACC_END: begin
               // product of the upper integral bits (47:16) sits 16 bits up
               acc_ff   <= acc_ff + (prod_ext <<< 16);
               state_ff <= ST_SAT_U;
            end
            ST_SAT_U: begin
               u_ff     <= u_in;
               state_ff <= ST_MUL_FX;
            end
            ST_MUL_FX: state_ff <= ST_MUL_FY;
            ST_MUL_FY: begin
               force_x_ff <= sat_force(prod_ff);
               state_ff   <= ST_MUL_FZ;
            end
            ST_MUL_FZ: begin
               force_y_ff <= sat_force(prod_ff);
               state_ff   <= ST_FZ;
            end
            ST_FZ: begin
               force_z_ff <= sat_force(prod_ff);
               state_ff   <= ST_DONE;
            end
            ST_DONE: begin
               // hand off once the output register is free
               if (rsp_free) begin
                  rsp_ff.drive_active <= active_ff;
                  rsp_ff.force_x      <= force_x_ff;
                  rsp_ff.force_y      <= force_y_ff;
                  rsp_ff.force_z      <= force_z_ff;
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Drive-off item clears the controller state
   a_drive_off_clears: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_data.drive_on
      |=> error_sum_ff == '0 && last_error_ff == '0)
      else $error("controller state not cleared by drive-off item");

   // An inactive result carries zero force
   a_inactive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.drive_active
      |-> rsp_data.force_x == '0 && rsp_data.force_y == '0 && rsp_data.force_z == '0)
      else $error("inactive result with nonzero force");

   // A finished item waits while the output register is still occupied
   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && rsp_valid_ff && !rsp_ready
      |=> state_ff == ST_DONE && rsp_valid_ff)
      else $error("pending result overwritten");

endmodule
